// ===== hw/rtl/fcfla_pkg.sv =====
// ----------------------------------------------------------------------------
// fcfla_pkg
// Shared types and codes for the fixed chunk free list allocator.
// ----------------------------------------------------------------------------
package fcfla_pkg;

    // Request kinds
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    // Configuration register indexes
    localparam int         CFG_IDX_W   = 1;
    localparam int         CFG_DATA_W  = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNKS_IN_USE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES   = 1'd1;

    // Field widths
    localparam int COUNT_W  = 9;
    localparam int BYTES_W  = 16;
    localparam int INDEX_W  = 8;
    localparam int OFFSET_W = 24;
    localparam int STATUS_W = 2;

    // Configuration reset values
    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;
    localparam logic [BYTES_W-1:0] BYTES_RESET = 16'd4;

    typedef enum logic [2:0] {
        S_SWEEP = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic take;      // latch request, read link of head
        logic commit;    // update list, load result
        logic sweep_wr;  // write one default link
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic rebuild;    // chunk count written this cycle
        logic sweep_last; // sweep at final entry
        logic out_free;   // output register can take a result
    } dp_status_t;

endpackage

// ===== hw/rtl/fcfla_ctrl.sv =====
// ----------------------------------------------------------------------------
// fcfla_ctrl
// Sequencer: link store sweep, request intake and commit.
// ----------------------------------------------------------------------------
module fcfla_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  fcfla_pkg::dp_status_t dp_status,
    output fcfla_pkg::dp_cmd_t    dp_cmd
);
    import fcfla_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_SWEEP;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        dp_cmd     = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_SWEEP: begin
                dp_cmd.sweep_wr = 1'b1;
                if (dp_status.sweep_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = !dp_status.rebuild;
                if (s_valid && !dp_status.rebuild) begin
                    dp_cmd.take = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold until the output register is free
                if (dp_status.out_free) begin
                    dp_cmd.commit = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_SWEEP;
            end
        endcase
        // restart the sweep on a new chunk count
        if (dp_status.rebuild) begin
            state_next = S_SWEEP;
        end
    end

endmodule

// ===== hw/rtl/fcfla_datapath.sv =====
// ----------------------------------------------------------------------------
// fcfla_datapath
// Configuration, head pointer, link store and result register.
// ----------------------------------------------------------------------------
module fcfla_datapath #(
    parameter int MAX_CHUNKS = 256
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  fcfla_pkg::dp_cmd_t                    dp_cmd,
    output fcfla_pkg::dp_status_t                 dp_status,
    input  logic                                  cfg_wr_en,
    input  logic [fcfla_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fcfla_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                  s_req_type,
    input  logic [fcfla_pkg::INDEX_W-1:0]         s_free_index,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [fcfla_pkg::STATUS_W-1:0]        m_status,
    output logic [fcfla_pkg::INDEX_W-1:0]         m_alloc_index,
    output logic [fcfla_pkg::OFFSET_W-1:0]        m_alloc_offset
);
    import fcfla_pkg::*;

    localparam int IDX_W  = $clog2(MAX_CHUNKS);
    localparam int LINK_W = IDX_W + 1;
    localparam int PROD_W = IDX_W + BYTES_W;
    localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(MAX_CHUNKS);
    localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(MAX_CHUNKS - 1);

    logic [LINK_W-1:0] link_mem [MAX_CHUNKS];

    logic [COUNT_W-1:0]  cfg_count_reg;
    logic [BYTES_W-1:0]  cfg_bytes_reg;
    logic [LINK_W-1:0]   head_reg,      head_next;
    logic [IDX_W-1:0]    sweep_cnt_reg, sweep_cnt_next;
    logic [LINK_W-1:0]   link_rdata_reg;
    logic                req_kind_reg;
    logic [INDEX_W-1:0]  req_idx_reg;
    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [INDEX_W-1:0]  m_index_reg;
    logic [OFFSET_W-1:0] m_offset_reg;

    logic [LINK_W-1:0]   eff_count;
    logic [LINK_W-1:0]   sweep_link;
    logic                rebuild;
    logic                sweep_last;
    logic                pool_empty;
    logic                free_ok;
    logic                alloc_ok;
    logic [IDX_W-1:0]    grant;
    logic [PROD_W-1:0]   prod;
    logic [STATUS_W-1:0] res_status;
    logic [INDEX_W-1:0]  res_index;
    logic [OFFSET_W-1:0] res_offset;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [LINK_W-1:0]   mem_wdata;

    assign rebuild    = cfg_wr_en && (cfg_index == CFG_CHUNKS_IN_USE);
    assign sweep_last = (sweep_cnt_reg == IDX_LAST);

    assign dp_status.rebuild    = rebuild;
    assign dp_status.sweep_last = sweep_last;
    assign dp_status.out_free   = !m_valid_reg || m_ready;

    // chunk count saturated to capacity
    always_comb begin
        if (32'(cfg_count_reg) > 32'(MAX_CHUNKS)) begin
            eff_count = LINK_NONE;
        end else begin
            eff_count = LINK_W'(cfg_count_reg);
        end
    end

    always_comb begin
        if ((32'(sweep_cnt_reg) + 32'd1) < 32'(eff_count)) begin
            sweep_link = LINK_W'(32'(sweep_cnt_reg) + 32'd1);
        end else begin
            sweep_link = LINK_NONE;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_count_reg <= COUNT_RESET;
            cfg_bytes_reg <= BYTES_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_CHUNKS_IN_USE: cfg_count_reg <= cfg_wdata[COUNT_W-1:0];
                CFG_CHUNK_BYTES:   cfg_bytes_reg <= cfg_wdata[BYTES_W-1:0];
                default: ;
            endcase
        end
    end

    // request evaluation on the latched item
    assign pool_empty = (head_reg >= LINK_NONE);
    assign free_ok    = 32'(req_idx_reg) < 32'(eff_count);
    assign alloc_ok   = (req_kind_reg == REQ_ALLOC) && !pool_empty;
    assign grant      = head_reg[IDX_W-1:0];
    assign prod       = PROD_W'(grant) * PROD_W'(cfg_bytes_reg);

    always_comb begin
        res_index  = '0;
        res_offset = '0;
        if (req_kind_reg == REQ_ALLOC) begin
            res_status = pool_empty ? STAT_EMPTY : STAT_OK;
        end else begin
            res_status = free_ok ? STAT_OK : STAT_RANGE;
        end
        if (alloc_ok) begin
            res_index  = INDEX_W'(grant);
            res_offset = OFFSET_W'(prod);
        end
    end

    // head pointer and sweep counter
    always_comb begin
        head_next      = head_reg;
        sweep_cnt_next = sweep_cnt_reg;
        if (rebuild) begin
            sweep_cnt_next = '0;
        end else if (dp_cmd.sweep_wr) begin
            sweep_cnt_next = sweep_last ? '0 : sweep_cnt_reg + 1'b1;
        end
        if (dp_cmd.sweep_wr) begin
            head_next = (eff_count != '0) ? '0 : LINK_NONE;
        end else if (dp_cmd.commit) begin
            if (alloc_ok) begin
                head_next = link_rdata_reg;
            end else if ((req_kind_reg == REQ_FREE) && free_ok) begin
                head_next = LINK_W'(req_idx_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg      <= '0;
            sweep_cnt_reg <= '0;
        end else begin
            head_reg      <= head_next;
            sweep_cnt_reg <= sweep_cnt_next;
        end
    end

    // link store: one write port, one registered read port
    assign mem_we    = dp_cmd.sweep_wr ||
                       (dp_cmd.commit && (req_kind_reg == REQ_FREE) && free_ok);
    assign mem_waddr = dp_cmd.sweep_wr ? sweep_cnt_reg : IDX_W'(req_idx_reg);
    assign mem_wdata = dp_cmd.sweep_wr ? sweep_link : head_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (dp_cmd.take) begin
            link_rdata_reg <= link_mem[head_reg[IDX_W-1:0]];
        end
    end

    // request latch
    always_ff @(posedge aclk) begin
        if (dp_cmd.take) begin
            req_kind_reg <= s_req_type;
            req_idx_reg  <= s_free_index;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (dp_cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.commit) begin
            m_status_reg <= res_status;
            m_index_reg  <= res_index;
            m_offset_reg <= res_offset;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_alloc_index  = m_index_reg;
    assign m_alloc_offset = m_offset_reg;

endmodule

// ===== hw/rtl/fixed_chunk_free_list_allocator_unit.sv =====
// An accepted item is latched, then committed into the output register from the
// EXEC state once that register is free; a new item is taken only after the commit.
// The pop reads the head's link from the link store (registered read port) before
// the head can move. Reset and every chunks_in_use write start a sweep of all
// MAX_CHUNKS entries that rewrites the link store, one entry a cycle, with s_ready low throughout.
// Reset is synchronous, active low; chunks_in_use resets to 256, chunk_bytes to 4.
// ----------------------------------------------------------------------------
// fixed_chunk_free_list_allocator_unit
// Pool of equal-size chunks kept as a free list; allocate pops, free pushes.
// ----------------------------------------------------------------------------
module fixed_chunk_free_list_allocator_unit #(
    parameter int MAX_CHUNKS = 256
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [fcfla_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fcfla_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_req_type,
    input  logic [fcfla_pkg::INDEX_W-1:0]     s_free_index,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [fcfla_pkg::STATUS_W-1:0]    m_status,
    output logic [fcfla_pkg::INDEX_W-1:0]     m_alloc_index,
    output logic [fcfla_pkg::OFFSET_W-1:0]    m_alloc_offset
);
    import fcfla_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    fcfla_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd)
    );

    fcfla_datapath #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .dp_cmd         (dp_cmd),
        .dp_status      (dp_status),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_req_type     (s_req_type),
        .s_free_index   (s_free_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_alloc_index  (m_alloc_index),
        .m_alloc_offset (m_alloc_offset)
    );

endmodule

// ===== hw/rtl/fcfla_checker.sv =====
// ----------------------------------------------------------------------------
// fcfla_checker
// Port-level checks for the chunk allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fcfla_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [fcfla_pkg::STATUS_W-1:0]    m_status,
    input logic [fcfla_pkg::INDEX_W-1:0]     m_alloc_index,
    input logic [fcfla_pkg::OFFSET_W-1:0]    m_alloc_offset
);
    import fcfla_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) &&
        $stable(m_alloc_index) && $stable(m_alloc_offset))
        else $error("result changed while stalled");

    // the link store sweep follows reset
    a_sweep_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("item taken during link store sweep");

    // one item in flight: no intake in the cycle after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while one is in flight");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STAT_OK) || (m_status == STAT_EMPTY) ||
        (m_status == STAT_RANGE))
        else $error("undefined status code");

    // results with a status other than OK carry zero index and offset
    a_no_grant_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STAT_OK) |->
        (m_alloc_index == '0) && (m_alloc_offset == '0))
        else $error("non-granting result carries a chunk");

endmodule

bind fixed_chunk_free_list_allocator_unit fcfla_checker u_fcfla_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_status       (m_status),
    .m_alloc_index  (m_alloc_index),
    .m_alloc_offset (m_alloc_offset)
);

// ===== verif/fixed_chunk_free_list_allocator_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_chunk_free_list_allocator_unit_tb
// Self-checking bench for the chunk pool allocator. A queue-fed driver sends
// allocate and free requests with random gaps, and a monitor stalls the result
// side at random. Every result is checked against a local model of the free
// list, and the register settings are changed between phases.
// ----------------------------------------------------------------------------
module fixed_chunk_free_list_allocator_unit_tb;
    import fcfla_pkg::*;

    localparam int         POOL_DEPTH  = 256;
    localparam logic [8:0] LINK_NONE   = 9'd256;
    localparam int         QUIET_LIMIT = 4000;
    localparam int         ITEM_TARGET = 1750;

    typedef struct packed {
        logic               kind;
        logic [INDEX_W-1:0] idx;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  index;
        logic [OFFSET_W-1:0] offset;
    } reply_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_req_type = 1'b0;
    logic [INDEX_W-1:0]    s_free_index = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [STATUS_W-1:0]   m_status;
    logic [INDEX_W-1:0]    m_alloc_index;
    logic [OFFSET_W-1:0]   m_alloc_offset;

    fixed_chunk_free_list_allocator_unit #(.MAX_CHUNKS(POOL_DEPTH)) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_free_index   (s_free_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_alloc_index  (m_alloc_index),
        .m_alloc_offset (m_alloc_offset)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Pool model: register copies, free list and which chunks are handed out
    logic [COUNT_W-1:0] count_reg = COUNT_RESET;
    logic [BYTES_W-1:0] bytes_reg = BYTES_RESET;
    logic [8:0]         head;
    logic [8:0]         links [POOL_DEPTH];
    bit                 held [POOL_DEPTH];

    req_t   req_q[$];
    reply_t reply_q[$];
    req_t   drv_req;

    bit steady = 1'b0;
    int gap_left = 0;
    int stall_left = 0;
    int quiet = 0;
    int errors = 0;
    int n_items = 0;
    int n_results = 0;
    int n_grant = 0;
    int n_empty = 0;
    int n_freed = 0;
    int n_range = 0;
    int n_writes = 0;

    function automatic int live_count();
        return (count_reg > COUNT_W'(POOL_DEPTH)) ? POOL_DEPTH : int'(count_reg);
    endfunction

    function automatic void rebuild_pool();
        int n;
        n = live_count();
        for (int i = 0; i < POOL_DEPTH; i++) begin
            links[i] = (i + 1 < n) ? 9'(i + 1) : LINK_NONE;
            held[i]  = 1'b0;
        end
        head = (n > 0) ? 9'd0 : LINK_NONE;
    endfunction

    // Pop on allocate, push on free; queue the result this item will produce
    task automatic pool_step(input logic kind, input logic [INDEX_W-1:0] idx);
        reply_t r;
        r = '0;
        if (kind == REQ_ALLOC) begin
            if (head == LINK_NONE) begin
                r.status = STAT_EMPTY;
                n_empty++;
            end else begin
                r.status = STAT_OK;
                r.index  = head[7:0];
                r.offset = OFFSET_W'(head[7:0]) * OFFSET_W'(bytes_reg);
                held[head[7:0]] = 1'b1;
                head = links[head[7:0]];
                n_grant++;
            end
        end else if (int'(idx) >= live_count()) begin
            r.status = STAT_RANGE;
            n_range++;
        end else begin
            r.status   = STAT_OK;
            links[idx] = head;
            head       = {1'b0, idx};
            held[idx]  = 1'b0;
            n_freed++;
        end
        reply_q.push_back(r);
    endtask

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                pool_step(s_req_type, s_free_index);
                n_items++;
            end
            // hold the item until it is taken
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    s_valid <= 1'b0;
                    gap_left--;
                end else if (req_q.size() != 0) begin
                    drv_req = req_q.pop_front();
                    s_valid      <= 1'b1;
                    s_req_type   <= drv_req.kind;
                    s_free_index <= drv_req.idx;
                    gap_left = steady ? 0 : idle_len();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_reply();
        reply_t want;
        n_results++;
        if (reply_q.size() == 0) begin
            $display("%0t: unexpected result: status %0d index %0d offset %0d",
                     $time, m_status, m_alloc_index, m_alloc_offset);
            errors++;
        end else begin
            want = reply_q.pop_front();
            if (m_status !== want.status) begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, m_status);
                errors++;
            end
            if (m_alloc_index !== want.index) begin
                $display("%0t: alloc_index mismatch: expected %0d, actual %0d",
                         $time, want.index, m_alloc_index);
                errors++;
            end
            if (m_alloc_offset !== want.offset) begin
                $display("%0t: alloc_offset mismatch: expected %0d, actual %0d",
                         $time, want.offset, m_alloc_offset);
                errors++;
            end
        end
    endtask

    // Monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) check_reply();
            if (stall_left != 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (!steady && $urandom_range(0, 99) < 20) begin
                m_ready <= 1'b0;
                stall_left = idle_len();
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= QUIET_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, quiet);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic bit busy();
        return req_q.size() != 0 || s_valid || reply_q.size() != 0;
    endfunction

    task automatic drain();
        do @(negedge aclk); while (busy());
    endtask

    // Wait until nothing is in flight and the list sweep is done
    task automatic settle();
        drain();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        settle();
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        n_writes++;
        if (idx == CFG_CHUNKS_IN_USE) begin
            count_reg = data[COUNT_W-1:0];
            rebuild_pool();
        end else begin
            bytes_reg = data;
        end
    endtask

    function automatic void add_req(input logic kind, input logic [INDEX_W-1:0] idx);
        req_t r;
        r.kind = kind;
        r.idx  = idx;
        req_q.push_back(r);
    endfunction

    // Mixed batch: frees mostly return chunks that are out, some hit stray indexes
    task automatic run_batch(input int n, input int alloc_pct);
        logic [INDEX_W-1:0] owned[$];
        logic [INDEX_W-1:0] pick;
        int live;
        int j;
        int r;
        live = live_count();
        for (int i = 0; i < live; i++) begin
            if (held[i]) owned.push_back(INDEX_W'(i));
        end
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < alloc_pct) begin
                add_req(REQ_ALLOC, INDEX_W'($urandom));
            end else begin
                r = $urandom_range(0, 99);
                if (r < 75 && owned.size() != 0) begin
                    j = $urandom_range(0, owned.size() - 1);
                    pick = owned[j];
                    owned.delete(j);
                end else if (r < 88 && live > 0) begin
                    pick = INDEX_W'($urandom_range(0, live - 1));
                end else if (live < POOL_DEPTH) begin
                    pick = INDEX_W'($urandom_range(live, POOL_DEPTH - 1));
                end else begin
                    pick = INDEX_W'($urandom);
                end
                add_req(REQ_FREE, pick);
            end
        end
        drain();
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return CFG_DATA_W'($urandom_range(1, 16));
        if (r < 70) return CFG_DATA_W'($urandom_range(17, 64));
        if (r < 78) return CFG_DATA_W'($urandom_range(65, 255));
        if (r < 88) return CFG_DATA_W'(256);
        if (r < 93) return '0;
        // above capacity, with junk in the unused upper bits
        return {7'($urandom), 9'($urandom_range(257, 511))};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_bytes();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return 16'hFFFF;
        if (r < 30) return 16'd1;
        return CFG_DATA_W'($urandom);
    endfunction

    initial begin
        int alloc_pct;
        int batches;
        rebuild_pool();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        settle();

        // Directed: reset list order, push of a never-granted chunk
        add_req(REQ_ALLOC, 8'hFF);
        add_req(REQ_ALLOC, 8'h00);
        add_req(REQ_FREE, 8'd0);
        add_req(REQ_FREE, 8'd255);
        add_req(REQ_ALLOC, 8'h00);
        add_req(REQ_ALLOC, 8'hFF);
        add_req(REQ_ALLOC, 8'h5A);

        // Single chunk: empty pool, out of range, double free granted twice
        write_reg(CFG_CHUNKS_IN_USE, 16'd1);
        write_reg(CFG_CHUNK_BYTES, 16'hFFFF);
        add_req(REQ_ALLOC, 8'h00);
        add_req(REQ_ALLOC, 8'h00);
        add_req(REQ_FREE, 8'd1);
        add_req(REQ_FREE, 8'd0);
        add_req(REQ_FREE, 8'd0);
        add_req(REQ_ALLOC, 8'h00);
        add_req(REQ_ALLOC, 8'h00);

        // Zero chunks, zero chunk size
        write_reg(CFG_CHUNKS_IN_USE, 16'd0);
        write_reg(CFG_CHUNK_BYTES, 16'd0);
        add_req(REQ_ALLOC, 8'h00);
        add_req(REQ_FREE, 8'd0);
        add_req(REQ_FREE, 8'd255);

        // Count above capacity saturates; largest offset
        write_reg(CFG_CHUNKS_IN_USE, 16'd511);
        write_reg(CFG_CHUNK_BYTES, 16'hFFFF);
        add_req(REQ_FREE, 8'd255);
        add_req(REQ_ALLOC, 8'h00);
        add_req(REQ_ALLOC, 8'h00);
        write_reg(CFG_CHUNK_BYTES, 16'd0);
        add_req(REQ_ALLOC, 8'h00);
        add_req(REQ_FREE, 8'd1);
        drain();

        // Random phases
        while (n_items < ITEM_TARGET) begin
            if ($urandom_range(0, 2) == 0) write_reg(CFG_CHUNK_BYTES, pick_bytes());
            if ($urandom_range(0, 1) == 0) write_reg(CFG_CHUNKS_IN_USE, pick_count());
            @(negedge aclk);
            steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0: alloc_pct = 30;
                1: alloc_pct = 50;
                default: alloc_pct = 85;
            endcase
            batches = (live_count() >= 128) ? $urandom_range(10, 25) : $urandom_range(3, 8);
            repeat (batches) run_batch($urandom_range(4, 24), alloc_pct);
            steady = 1'b0;
        end

        drain();
        repeat (10) @(posedge aclk);
        if (reply_q.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, reply_q.size());
            errors += reply_q.size();
        end
        $display("Covered %0d requests over %0d register writes: %0d grants, %0d empty",
                 n_items, n_writes, n_grant, n_empty);
        $display("  %0d frees taken, %0d frees out of range, %0d results checked",
                 n_freed, n_range, n_results);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
